@@ hw/rtl/terrain_alpha_layer_decoder_macros.svh @@
// assertion macros shared by the terrain alpha layer decoder modules
`ifndef TERRAIN_ALPHA_LAYER_DECODER_MACROS_SVH
`define TERRAIN_ALPHA_LAYER_DECODER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define TALD_ASSERT_IMPL(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("tald assertion failed");

// next-cycle implication, disabled while in reset
`define TALD_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("tald assertion failed");

`endif

@@ hw/rtl/tald_pkg.sv @@
// shared types and constants for the terrain alpha layer decoder
`timescale 1ns / 1ps

package tald_pkg;

    // default map edge and job queue depth
    localparam int unsigned MAP_DIM_DEFAULT     = 64;
    localparam int unsigned JOB_QUEUE_DEPTH_DEF = 2;

    // field widths
    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned LAYER_BYTES_W = 16;
    localparam int unsigned START_W       = 12;
    localparam int unsigned RUN_LEN_W     = 13;

    // results one item can cause
    localparam int unsigned MAX_RESULTS = 5;
    localparam int unsigned RES_IDX_W   = $clog2(MAX_RESULTS);
    localparam int unsigned RES_CNT_W   = $clog2(MAX_RESULTS + 1);

    // configuration port
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_COMPRESSED_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAYER_BYTES     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNSET_FILL      = 2'd2;

    // compressed stream parse phase
    typedef enum logic [1:0] {
        PH_CMD  = 2'd0,
        PH_FILL = 2'd1,
        PH_COPY = 2'd2
    } phase_t;

    // decode form picked from the registers
    typedef enum logic [1:0] {
        MODE_COMP   = 2'd0,
        MODE_RAW    = 2'd1,
        MODE_PACKED = 2'd2,
        MODE_FAIL   = 2'd3
    } mode_t;

    typedef struct packed {
        logic                     compressed_mode;
        logic [LAYER_BYTES_W-1:0] layer_bytes;
        logic [BYTE_W-1:0]        unset_fill;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_data;
    } in_item_t;

    typedef struct packed {
        logic [START_W-1:0]   start_index;
        logic [RUN_LEN_W-1:0] run_length;
        logic [BYTE_W-1:0]    texel_value;
        logic                 closing;
        logic                 decode_ok;
    } out_item_t;

    // all results caused by one input item
    typedef struct packed {
        logic [RES_CNT_W-1:0]              count;
        out_item_t [MAX_RESULTS-1:0]       res;
    } job_t;

endpackage

@@ hw/rtl/tald_stream_if.sv @@
// valid/ready stream channel with source and sink views
`timescale 1ns / 1ps

interface tald_stream_if
    import tald_pkg::*;
#(
    parameter type item_t = in_item_t
) ();

    logic  valid;
    logic  ready;
    item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);

endinterface

@@ hw/rtl/tald_front.sv @@
// front end: parses each byte and builds the list of runs it causes
`timescale 1ns / 1ps
`include "terrain_alpha_layer_decoder_macros.svh"

module tald_front
    import tald_pkg::*;
#(
    parameter int unsigned MAP_DIM = MAP_DIM_DEFAULT
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     accept,
    input  in_item_t item,
    input  cfg_t     cfg,
    output job_t     job
);

    localparam int unsigned MAP_SIZE    = MAP_DIM * MAP_DIM;
    localparam int unsigned PACKED_SIZE = MAP_SIZE / 2;
    localparam int unsigned PW          = $clog2(MAP_SIZE + 1);
    localparam int unsigned IW          = (PW + 1 > RUN_LEN_W) ? PW + 1 : RUN_LEN_W;
    localparam int unsigned CW          = $clog2(MAP_DIM);
    localparam int unsigned RW          = $clog2(2 * MAP_DIM + 1);
    localparam int unsigned LW          = (PW > LAYER_BYTES_W) ? PW : LAYER_BYTES_W;
    localparam int unsigned NCAND       = 4;

    logic [PW-1:0] wp_reg, wp_next, wp_upd;
    logic [PW-1:0] bc_reg, bc_next, bc_inc;
    phase_t        phase_reg, phase_next, phase_upd;
    logic [7:0]    pend_reg, pend_next, pend_upd;
    logic [7:0]    prior_reg, prior_next;
    logic [CW-1:0] col_reg, col_next, col_adv, col1;
    logic [RW-1:0] row_reg, row_next, row_adv, row1;

    mode_t         mode;
    logic          wp_room, bc_room, packed_act;
    logic [IW-1:0] fill_len;
    logic [CW:0]   col_step, col1_raw;
    logic [7:0]    v0, v1;
    logic [IW-1:0] t0;

    logic          cand_v [NCAND];
    logic [IW-1:0] cand_i [NCAND];
    logic [IW-1:0] cand_l [NCAND];
    logic [7:0]    cand_x [NCAND];

    logic [IW-1:0] close_start, close_len;
    logic          close_ok;

    logic [IW-1:0]        rs  [MAX_RESULTS];
    logic [IW-1:0]        rl  [MAX_RESULTS];
    logic [7:0]           rv  [MAX_RESULTS];
    logic                 rc  [MAX_RESULTS];
    logic                 rok [MAX_RESULTS];
    logic [RES_CNT_W-1:0] n;
    logic [RES_IDX_W-1:0] prev, slot;

    // decode form from the registers of this moment
    always_comb
    begin
        if (cfg.compressed_mode)
            mode = MODE_COMP;
        else if (LW'(cfg.layer_bytes) >= LW'(MAP_SIZE))
            mode = MODE_RAW;
        else if (LW'(cfg.layer_bytes) >= LW'(PACKED_SIZE))
            mode = MODE_PACKED;
        else
            mode = MODE_FAIL;
    end

    // shared conditions and sizes
    assign wp_room    = wp_reg < PW'(MAP_SIZE);
    assign bc_room    = bc_reg < PW'(MAP_SIZE);
    assign packed_act = (mode == MODE_PACKED) && (bc_reg < PW'(PACKED_SIZE));
    assign bc_inc     = bc_room ? bc_reg + 1'b1 : bc_reg;
    assign fill_len   = (IW'(pend_reg) < (IW'(MAP_SIZE) - IW'(wp_reg)))
                        ? IW'(pend_reg) : (IW'(MAP_SIZE) - IW'(wp_reg));

    // raster position of the first texel of the next packed byte
    assign col_step = {1'b0, col_reg} + (CW+1)'(2);
    assign col_adv  = (col_step >= (CW+1)'(MAP_DIM))
                      ? CW'(col_step - (CW+1)'(MAP_DIM)) : CW'(col_step);
    assign row_adv  = (col_step >= (CW+1)'(MAP_DIM)) ? row_reg + 1'b1 : row_reg;

    // second texel of the byte, which may wrap to the next row
    assign col1_raw = {1'b0, col_reg} + (CW+1)'(1);
    assign col1     = (col1_raw == (CW+1)'(MAP_DIM)) ? '0 : CW'(col1_raw);
    assign row1     = (col1_raw == (CW+1)'(MAP_DIM)) ? row_reg + 1'b1 : row_reg;

    // packed values; the last column repeats the one before it
    assign v0 = (col_reg == CW'(MAP_DIM - 1)) ? prior_reg
                : {item.data_byte[3:0], item.data_byte[3:0]};
    assign v1 = (col1 == CW'(MAP_DIM - 1)) ? v0
                : {item.data_byte[7:4], item.data_byte[7:4]};
    assign t0 = IW'({bc_reg, 1'b0});

    // parse phase next state
    always_comb
    begin
        phase_upd = phase_reg;
        pend_upd  = pend_reg;
        wp_upd    = wp_reg;
        if (mode == MODE_COMP && wp_room)
        begin
            case (phase_reg)
                PH_FILL:
                begin
                    wp_upd    = PW'(IW'(wp_reg) + fill_len);
                    phase_upd = PH_CMD;
                    pend_upd  = '0;
                end
                PH_COPY:
                begin
                    wp_upd   = wp_reg + 1'b1;
                    pend_upd = pend_reg - 8'd1;
                    if (pend_upd == '0)
                        phase_upd = PH_CMD;
                end
                default:
                begin
                    pend_upd  = {1'b0, item.data_byte[6:0]} + 8'd1;
                    phase_upd = item.data_byte[7] ? PH_FILL : PH_COPY;
                end
            endcase
        end
    end

    // state next values; the last byte returns everything to reset
    always_comb
    begin
        phase_next = phase_reg;
        pend_next  = pend_reg;
        wp_next    = wp_reg;
        bc_next    = bc_reg;
        prior_next = prior_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        if (accept)
        begin
            if (item.end_of_data)
            begin
                phase_next = PH_CMD;
                pend_next  = '0;
                wp_next    = '0;
                bc_next    = '0;
                prior_next = '0;
                col_next   = '0;
                row_next   = '0;
            end
            else
            begin
                phase_next = phase_upd;
                pend_next  = pend_upd;
                wp_next    = wp_upd;
                bc_next    = bc_inc;
                if (packed_act)
                    prior_next = v1;
                if (bc_room)
                begin
                    col_next = col_adv;
                    row_next = row_adv;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_CMD;
            pend_reg  <= '0;
            wp_reg    <= '0;
            bc_reg    <= '0;
            prior_reg <= '0;
            col_reg   <= '0;
            row_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            pend_reg  <= pend_next;
            wp_reg    <= wp_next;
            bc_reg    <= bc_next;
            prior_reg <= prior_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
        end
    end

    // texel runs this byte writes, before merging
    always_comb
    begin
        for (int k = 0; k < NCAND; k++)
        begin
            cand_v[k] = 1'b0;
            cand_i[k] = '0;
            cand_l[k] = '0;
            cand_x[k] = '0;
        end
        case (mode)
            MODE_COMP:
            begin
                if (wp_room && phase_reg == PH_FILL)
                begin
                    cand_v[0] = 1'b1;
                    cand_i[0] = IW'(wp_reg);
                    cand_l[0] = fill_len;
                    cand_x[0] = item.data_byte;
                end
                else if (wp_room && phase_reg == PH_COPY)
                begin
                    cand_v[0] = 1'b1;
                    cand_i[0] = IW'(wp_reg);
                    cand_l[0] = IW'(1);
                    cand_x[0] = item.data_byte;
                end
            end
            MODE_RAW:
            begin
                cand_v[0] = bc_room;
                cand_i[0] = IW'(bc_reg);
                cand_l[0] = IW'(1);
                cand_x[0] = item.data_byte;
            end
            MODE_PACKED:
            begin
                // last row is only written as the copy of the row above
                cand_v[0] = packed_act && (row_reg < RW'(MAP_DIM - 1));
                cand_i[0] = t0;
                cand_x[0] = v0;
                cand_v[1] = packed_act && (row1 < RW'(MAP_DIM - 1));
                cand_i[1] = t0 + IW'(1);
                cand_x[1] = v1;
                cand_v[2] = packed_act && (row_reg == RW'(MAP_DIM - 2));
                cand_i[2] = t0 + IW'(MAP_DIM);
                cand_x[2] = v0;
                cand_v[3] = packed_act && (row1 == RW'(MAP_DIM - 2));
                cand_i[3] = t0 + IW'(MAP_DIM + 1);
                cand_x[3] = v1;
                for (int k = 0; k < NCAND; k++)
                    cand_l[k] = IW'(1);
            end
            default:
            begin
            end
        endcase
    end

    // closing run over whatever is left, or the whole map on failure
    always_comb
    begin
        close_start = '0;
        close_len   = '0;
        close_ok    = 1'b1;
        if (mode == MODE_COMP)
        begin
            close_start = (wp_upd < PW'(MAP_SIZE)) ? IW'(wp_upd) : '0;
            close_len   = IW'(MAP_SIZE) - IW'(wp_upd);
        end
        else if (!((mode == MODE_RAW && bc_inc >= PW'(MAP_SIZE)) ||
                   (mode == MODE_PACKED && bc_inc >= PW'(PACKED_SIZE))))
        begin
            close_len = IW'(MAP_SIZE);
            close_ok  = 1'b0;
        end
    end

    // merge adjacent equal texels and append the closing run
    always_comb
    begin
        n    = '0;
        prev = '0;
        slot = '0;
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            rs[i]  = '0;
            rl[i]  = '0;
            rv[i]  = '0;
            rc[i]  = 1'b0;
            rok[i] = 1'b0;
        end
        for (int k = 0; k < NCAND; k++)
        begin
            prev = RES_IDX_W'(n - 1'b1);
            slot = RES_IDX_W'(n);
            if (cand_v[k])
            begin
                if (n != '0 && (rs[prev] + rl[prev]) == cand_i[k] && rv[prev] == cand_x[k])
                    rl[prev] = rl[prev] + cand_l[k];
                else
                begin
                    rs[slot] = cand_i[k];
                    rl[slot] = cand_l[k];
                    rv[slot] = cand_x[k];
                    n        = n + 1'b1;
                end
            end
        end
        slot = RES_IDX_W'(n);
        if (item.end_of_data)
        begin
            rs[slot]  = close_start;
            rl[slot]  = close_len;
            rv[slot]  = cfg.unset_fill;
            rc[slot]  = 1'b1;
            rok[slot] = close_ok;
            n         = n + 1'b1;
        end
    end

    // pack the job for the queue
    always_comb
    begin
        job.count = n;
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            job.res[i].start_index = rs[i][START_W-1:0];
            job.res[i].run_length  = rl[i][RUN_LEN_W-1:0];
            job.res[i].texel_value = rv[i];
            job.res[i].closing     = rc[i];
            job.res[i].decode_ok   = rok[i];
        end
    end

    `TALD_ASSERT_IMPL(a_wp_in_map, clk, rst_n, 1'b1, wp_reg <= PW'(MAP_SIZE))
    `TALD_ASSERT_IMPL(a_job_bounded, clk, rst_n, accept, job.count <= RES_CNT_W'(MAX_RESULTS))
    `TALD_ASSERT_NEXT(a_close_clears, clk, rst_n, accept && item.end_of_data,
        (bc_reg == '0) && (wp_reg == '0) && (phase_reg == PH_CMD) && (pend_reg == '0))

endmodule

@@ hw/rtl/tald_job_queue.sv @@
// short queue of result jobs between the front and back ends
`timescale 1ns / 1ps

module tald_job_queue
    import tald_pkg::*;
#(
    parameter int unsigned DEPTH = JOB_QUEUE_DEPTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    output logic valid,
    output job_t head_job,
    input  logic pop
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    job_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = count_reg == CNT_W'(DEPTH);
    assign valid    = count_reg != '0;
    assign head_job = entry_reg[rd_ptr_reg];

    // pointer wrap and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // job storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule

@@ hw/rtl/tald_back.sv @@
// back end: plays out the runs of each job through the output register
`timescale 1ns / 1ps
`include "terrain_alpha_layer_decoder_macros.svh"

module tald_back
    import tald_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic q_valid,
    input  job_t q_job,
    output logic pop,
    tald_stream_if.source res_out
);

    job_t                 job_reg;
    logic [RES_IDX_W-1:0] idx_reg;
    logic                 busy_reg;
    logic                 ov_reg;
    out_item_t            out_reg;
    logic                 advance, last;

    // move one run into the output register when it is free
    assign advance = busy_reg && (!ov_reg || res_out.ready);
    assign last    = advance && (RES_CNT_W'(idx_reg) == job_reg.count - 1'b1);
    assign pop     = q_valid && (!busy_reg || last);

    assign res_out.valid   = ov_reg;
    assign res_out.payload = out_reg;

    // job progress
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end
            else if (advance)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (last)
                    busy_reg <= 1'b0;
            end
            if (advance)
                ov_reg <= 1'b1;
            else if (res_out.ready)
                ov_reg <= 1'b0;
        end
    end

    // job and output payload
    always_ff @(posedge clk)
    begin
        if (pop)
            job_reg <= q_job;
        if (advance)
            out_reg <= job_reg.res[idx_reg];
    end

    `TALD_ASSERT_IMPL(a_job_not_empty, clk, rst_n, busy_reg, job_reg.count != '0)
    `TALD_ASSERT_IMPL(a_idx_in_job, clk, rst_n, busy_reg, RES_CNT_W'(idx_reg) < job_reg.count)
    `TALD_ASSERT_IMPL(a_out_held, clk, rst_n, busy_reg && (idx_reg != '0), ov_reg)

endmodule

@@ hw/rtl/terrain_alpha_layer_decoder.sv @@
// Terrain alpha layer decoder: takes one alpha byte per item and reports the rebuilt
// MAP_DIM x MAP_DIM map as runs of equal texels. The front end accepts a byte every
// cycle while its two-job queue has room and turns it into a job of zero to five runs
// in that same cycle; the back end sends runs one per cycle, while the output is ready,
// through its single output register. Raw and compressed bytes give at most one run,
// plus one on the last byte; packed bytes in the second to last row give up to four.
// A run passes through the job queue, the back end's job register and the output
// register. Registers may be written only while the block is idle.
`timescale 1ns / 1ps

module terrain_alpha_layer_decoder
    import tald_pkg::*;
#(
    parameter int unsigned MAP_DIM     = MAP_DIM_DEFAULT,
    parameter int unsigned QUEUE_DEPTH = JOB_QUEUE_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    tald_stream_if.sink           byte_in,
    tald_stream_if.source         res_out
);

    cfg_t cfg_reg;
    logic accept, push, q_full, q_valid, pop;
    job_t front_job, q_job;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_COMPRESSED_MODE: cfg_reg.compressed_mode <= cfg_data[0];
                CFG_LAYER_BYTES:     cfg_reg.layer_bytes     <= cfg_data[LAYER_BYTES_W-1:0];
                CFG_UNSET_FILL:      cfg_reg.unset_fill      <= cfg_data[BYTE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // input handshake; items with no runs skip the queue
    assign byte_in.ready = !q_full;
    assign accept        = byte_in.valid && !q_full;
    assign push          = accept && (front_job.count != '0);

    tald_front #(
        .MAP_DIM (MAP_DIM)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (byte_in.payload),
        .cfg    (cfg_reg),
        .job    (front_job)
    );

    tald_job_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (front_job),
        .full     (q_full),
        .valid    (q_valid),
        .head_job (q_job),
        .pop      (pop)
    );

    tald_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_job   (q_job),
        .pop     (pop),
        .res_out (res_out)
    );

endmodule

@@ bench/testbench.sv @@
// self-checking testbench for the terrain alpha layer decoder
`timescale 1ns / 1ps

module testbench
    import tald_pkg::*;
();

    localparam int unsigned DIM           = MAP_DIM_DEFAULT;
    localparam int unsigned MAP_SIZE      = DIM * DIM;
    localparam int unsigned PACKED_SIZE   = MAP_SIZE / 2;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned STALL_LIMIT   = 4000;
    localparam int unsigned RANDOM_ITEMS  = 80;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    tald_stream_if #(.item_t(in_item_t))  byte_ch ();
    tald_stream_if #(.item_t(out_item_t)) run_ch ();

    terrain_alpha_layer_decoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .byte_in      (byte_ch),
        .res_out      (run_ch)
    );

    // items waiting to be offered and runs still owed by the block
    in_item_t    pending_bytes[$];
    out_item_t   runs_due[$];
    out_item_t   byte_runs[$];
    logic [7:0]  layer_data[$];
    int unsigned bytes_queued;
    int unsigned bytes_taken;
    int unsigned mismatches;
    int unsigned stall_cycles;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    // register copies kept by the predictor
    logic        cfg_compressed;
    logic [15:0] cfg_layer_bytes;
    logic [7:0]  cfg_unset;

    // decode state kept by the predictor
    int unsigned wr_pos;
    int unsigned consumed;
    int unsigned pend_cnt;
    phase_t      phase;
    logic [7:0]  prior_texel;

    // clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // append a run to the runs of the current byte
    function automatic void add_run(input int unsigned start, input int unsigned len,
                                    input logic [7:0] val, input logic cl, input logic ok);
        out_item_t r;
        r.start_index = start[START_W-1:0];
        r.run_length  = len[RUN_LEN_W-1:0];
        r.texel_value = val;
        r.closing     = cl;
        r.decode_ok   = ok;
        if (byte_runs.size() < MAX_RESULTS)
            byte_runs.push_back(r);
    endfunction

    // one packed texel, merged into the previous run when it continues it
    function automatic void add_texel(input int unsigned idx, input logic [7:0] val);
        int n;
        n = byte_runs.size() - 1;
        if (n >= 0 && int'(byte_runs[n].start_index) + int'(byte_runs[n].run_length) == int'(idx)
            && byte_runs[n].texel_value == val)
            byte_runs[n].run_length = byte_runs[n].run_length + 1'b1;
        else
            add_run(idx, 1, val, 1'b0, 1'b0);
    endfunction

    // compressed stream: command, fill value or copied byte
    function automatic void decode_compressed(input logic [7:0] b);
        int unsigned room;
        int unsigned len;
        if (wr_pos >= MAP_SIZE)
            return;
        case (phase)
            PH_FILL:
            begin
                room = MAP_SIZE - wr_pos;
                len  = (pend_cnt < room) ? pend_cnt : room;
                add_run(wr_pos, len, b, 1'b0, 1'b0);
                wr_pos   = wr_pos + len;
                phase    = PH_CMD;
                pend_cnt = 0;
            end
            PH_COPY:
            begin
                add_run(wr_pos, 1, b, 1'b0, 1'b0);
                wr_pos   = wr_pos + 1;
                pend_cnt = (pend_cnt - 1) & 8'hFF;
                if (pend_cnt == 0)
                    phase = PH_CMD;
            end
            default:
            begin
                pend_cnt = {25'd0, b[6:0]} + 1;
                phase    = b[7] ? PH_FILL : PH_COPY;
            end
        endcase
    endfunction

    // packed 4-bit byte: two texels, last column and last row repeated
    function automatic void decode_packed(input logic [7:0] b);
        int unsigned tex_idx[2];
        logic [7:0]  tex_val[2];
        logic [3:0]  nib;
        for (int k = 0; k < 2; k++)
        begin
            tex_idx[k] = consumed * 2 + k;
            nib = (k == 0) ? b[3:0] : b[7:4];
            if (tex_idx[k] % DIM == DIM - 1)
                tex_val[k] = prior_texel;
            else
                tex_val[k] = 8'(nib * 17);
            prior_texel = tex_val[k];
        end
        for (int k = 0; k < 2; k++)
            if (tex_idx[k] / DIM < DIM - 1)
                add_texel(tex_idx[k], tex_val[k]);
        for (int k = 0; k < 2; k++)
            if (tex_idx[k] / DIM == DIM - 2)
                add_texel(tex_idx[k] + DIM, tex_val[k]);
    endfunction

    // work out the runs one accepted item causes
    function automatic void predict_runs(input logic [7:0] b, input logic last);
        mode_t       form;
        int unsigned needed;
        int unsigned wp;
        byte_runs.delete();
        needed = 0;
        if (cfg_compressed)
            form = MODE_COMP;
        else if (cfg_layer_bytes >= MAP_SIZE)
        begin
            form   = MODE_RAW;
            needed = MAP_SIZE;
        end
        else if (cfg_layer_bytes >= PACKED_SIZE)
        begin
            form   = MODE_PACKED;
            needed = PACKED_SIZE;
        end
        else
            form = MODE_FAIL;

        if (form == MODE_COMP)
            decode_compressed(b);
        else if (form == MODE_RAW && consumed < MAP_SIZE)
            add_run(consumed, 1, b, 1'b0, 1'b0);
        else if (form == MODE_PACKED && consumed < PACKED_SIZE)
            decode_packed(b);
        if (consumed < MAP_SIZE)
            consumed = consumed + 1;

        // closing run and return to the start of a layer
        if (last)
        begin
            if (form == MODE_COMP)
            begin
                wp = (wr_pos <= MAP_SIZE) ? wr_pos : MAP_SIZE;
                add_run((wp < MAP_SIZE) ? wp : 0, MAP_SIZE - wp, cfg_unset, 1'b1, 1'b1);
            end
            else if (form != MODE_FAIL && consumed >= needed)
                add_run(0, 0, cfg_unset, 1'b1, 1'b1);
            else
                add_run(0, MAP_SIZE, cfg_unset, 1'b1, 1'b0);
            wr_pos      = 0;
            consumed    = 0;
            phase       = PH_CMD;
            pend_cnt    = 0;
            prior_texel = 8'd0;
        end
        foreach (byte_runs[i])
            runs_due.push_back(byte_runs[i]);
    endfunction

    function automatic void compare_field(input string name, input int unsigned want,
                                          input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $realtime, name, want, got);
            mismatches++;
        end
    endfunction

    // driver: offers pending items, predicts each accepted one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_ch.valid   <= 1'b0;
            byte_ch.payload <= '0;
        end
        else
        begin
            if (byte_ch.valid && byte_ch.ready)
            begin
                predict_runs(byte_ch.payload.data_byte, byte_ch.payload.end_of_data);
                bytes_taken++;
            end
            if (!byte_ch.valid || byte_ch.ready)
            begin
                if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    byte_ch.valid   <= 1'b1;
                    byte_ch.payload <= pending_bytes.pop_front();
                end
                else
                    byte_ch.valid <= 1'b0;
            end
        end
    end

    // monitor: checks each accepted run against the oldest one owed
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            run_ch.ready <= 1'b0;
        else
        begin
            if (run_ch.valid && run_ch.ready)
            begin
                if (runs_due.size() == 0)
                begin
                    $display("%0t: unexpected run, expected none actual start %0d len %0d val %0d",
                             $realtime, run_ch.payload.start_index, run_ch.payload.run_length,
                             run_ch.payload.texel_value);
                    mismatches++;
                end
                else
                begin
                    compare_field("start_index", runs_due[0].start_index,
                                  run_ch.payload.start_index);
                    compare_field("run_length", runs_due[0].run_length,
                                  run_ch.payload.run_length);
                    compare_field("texel_value", runs_due[0].texel_value,
                                  run_ch.payload.texel_value);
                    compare_field("closing", runs_due[0].closing, run_ch.payload.closing);
                    compare_field("decode_ok", runs_due[0].decode_ok, run_ch.payload.decode_ok);
                    void'(runs_due.pop_front());
                end
            end
            run_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge clk)
    begin
        if ((byte_ch.valid && byte_ch.ready) || (run_ch.valid && run_ch.ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    task automatic queue_byte(input logic [7:0] b, input logic last);
        in_item_t it;
        it.data_byte   = b;
        it.end_of_data = last;
        pending_bytes.push_back(it);
        bytes_queued++;
    endtask

    // hold the sender until every owed run has come and the block has settled
    task automatic wait_idle();
        do
            @(negedge clk);
        while (bytes_taken != bytes_queued || runs_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    task automatic set_layer_cfg(input logic comp, input int unsigned lb, input int unsigned fill);
        write_reg(CFG_COMPRESSED_MODE, comp);
        write_reg(CFG_LAYER_BYTES, lb);
        write_reg(CFG_UNSET_FILL, fill);
        cfg_compressed  = comp;
        cfg_layer_bytes = lb[15:0];
        cfg_unset       = fill[7:0];
    endtask

    // mostly compressed, some raw, packed and too short layers
    task automatic random_cfg();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            set_layer_cfg(1'b1, $urandom_range(0, 65535), $urandom_range(0, 255));
        else if (sel < 7)
            set_layer_cfg(1'b0, $urandom_range(MAP_SIZE, 65535), $urandom_range(0, 255));
        else if (sel < 9)
            set_layer_cfg(1'b0, $urandom_range(PACKED_SIZE, MAP_SIZE - 1),
                          $urandom_range(0, 255));
        else
            set_layer_cfg(1'b0, $urandom_range(0, PACKED_SIZE - 1), $urandom_range(0, 255));
    endtask

    // queue the layer bytes, last one marked; a split point changes registers mid-layer
    task automatic send_layer(input int split);
        int i;
        for (i = 0; i < layer_data.size(); i++)
        begin
            if (split > 0 && i == split)
            begin
                wait_idle();
                random_cfg();
            end
            queue_byte(layer_data[i], i == layer_data.size() - 1);
        end
    endtask

    task automatic directed_layer(input logic comp, input int unsigned lb,
                                  input int unsigned fill);
        wait_idle();
        set_layer_cfg(comp, lb, fill);
        send_layer(0);
        layer_data.delete();
    endtask

    // well-formed compressed commands with random content
    task automatic build_compressed(input int ncmd);
        int unsigned cnt;
        int c;
        int j;
        for (c = 0; c < ncmd; c++)
        begin
            if ($urandom_range(0, 1))
            begin
                layer_data.push_back(8'h80 | 8'($urandom_range(0, 127)));
                layer_data.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                cnt = $urandom_range(1, 6);
                layer_data.push_back(8'(cnt - 1));
                for (j = 0; j < cnt; j++)
                    layer_data.push_back(8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial
    begin
        int unsigned random_items;
        int unsigned wp;
        int unsigned cnt;
        int cut;
        int i;

        clk             = 1'b0;
        rst_n           = 1'b0;
        cfg_write_en    = 1'b0;
        cfg_index       = CFG_COMPRESSED_MODE;
        cfg_data        = '0;
        bytes_queued    = 0;
        bytes_taken     = 0;
        mismatches      = 0;
        random_items    = 0;
        send_idle_pct   = 28;
        recv_idle_pct   = 49;
        cfg_compressed  = 1'b0;
        cfg_layer_bytes = '0;
        cfg_unset       = '0;
        wr_pos          = 0;
        consumed        = 0;
        phase           = PH_CMD;
        pend_cnt        = 0;
        prior_texel     = 8'd0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // registers at reset values: layer too short, decode fails
        layer_data = '{8'h00, 8'hFF};
        send_layer(0);
        layer_data.delete();

        // compressed: full fill, copy, single fill, then a copy cut short
        layer_data = '{8'hFF, 8'h00, 8'h02, 8'hA5, 8'h5A, 8'hFF, 8'h80, 8'h7F,
                       8'h7F, 8'h12, 8'h34};
        directed_layer(1'b1, 65535, 255);
        // stream ends on a fill command
        layer_data = '{8'h90};
        directed_layer(1'b1, 65535, 255);
        // just below packed size, packed ending early, top of packed, raw ending early
        layer_data = '{8'h3C};
        directed_layer(1'b0, PACKED_SIZE - 1, 0);
        layer_data = '{8'h11, 8'hF0, 8'h00};
        directed_layer(1'b0, PACKED_SIZE, 17);
        layer_data = '{8'hAB};
        directed_layer(1'b0, MAP_SIZE - 1, 255);
        layer_data = '{8'h01, 8'h80};
        directed_layer(1'b0, MAP_SIZE, 0);
        layer_data = '{8'hFE};
        directed_layer(1'b0, 65535, 128);

        // compressed layer filling the whole map, later bytes ignored
        wp = 0;
        while (wp < MAP_SIZE)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                layer_data.push_back(8'h01);
                layer_data.push_back(8'($urandom_range(0, 255)));
                layer_data.push_back(8'($urandom_range(0, 255)));
                wp = wp + 2;
            end
            else
            begin
                cnt = $urandom_range(100, 128);
                layer_data.push_back(8'h80 | 8'(cnt - 1));
                layer_data.push_back(8'($urandom_range(0, 255)));
                wp = wp + cnt;
            end
        end
        for (i = 0; i < 3; i++)
            layer_data.push_back(8'($urandom_range(0, 255)));
        directed_layer(1'b1, 0, 0);

        wait_idle();
        send_idle_pct = 49;
        recv_idle_pct = 28;

        // random layers under random registers
        while (random_items < RANDOM_ITEMS)
        begin
            if (random_items >= RANDOM_ITEMS / 2)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            wait_idle();
            random_cfg();
            if (!cfg_compressed || $urandom_range(0, 9) == 0)
            begin
                // raw, packed or too short layer, or noise in compressed mode
                cnt = $urandom_range(1, 10);
                for (i = 0; i < cnt; i++)
                    layer_data.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                build_compressed($urandom_range(1, 6));
                // broken stream: cut anywhere
                if ($urandom_range(0, 4) == 0)
                begin
                    cut = $urandom_range(1, layer_data.size());
                    while (layer_data.size() > cut)
                        void'(layer_data.pop_back());
                end
            end
            random_items = random_items + layer_data.size();
            if (layer_data.size() > 2 && $urandom_range(0, 4) == 0)
                send_layer($urandom_range(1, layer_data.size() - 1));
            else
                send_layer(0);
            layer_data.delete();
        end

        wait_idle();
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
